@@ src/mi3_pkg.sv @@
`default_nettype none
package mi3_pkg;

    localparam int MAT_W        = 32;
    localparam int N_ELEM       = 9;
    localparam int N_DET        = 3;
    localparam int COF_W        = 2 * MAT_W + 1;
    localparam int DET_W        = 99;
    localparam int DMAG_W       = DET_W - 1;
    localparam int Q_W          = 32;
    localparam int REM_W        = 130;
    localparam int DIV_STAGES   = Q_W + 1;
    localparam int FRONT_STAGES = 6;

    localparam logic [Q_W-1:0] SAT_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] SAT_MIN = {1'b1, {(Q_W-1){1'b0}}};

    // adjugate entry i = m[a]*m[b] - m[c]*m[d], entries in row-major order
    localparam int COF_IDX [N_ELEM][4] = '{
        '{4, 8, 7, 5}, '{7, 2, 1, 8}, '{1, 5, 4, 2},
        '{6, 5, 3, 8}, '{0, 8, 6, 2}, '{3, 2, 0, 5},
        '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
    };

    // determinant by expansion along row 0
    localparam int DET_COF [N_DET] = '{0, 3, 6};

    typedef logic signed [MAT_W-1:0] t_elem;

    typedef struct packed {
        logic [COF_W-1:0] mag;
        logic             neg;
    } t_num;

    typedef struct packed {
        logic [Q_W-1:0] quo;
        logic           ovf;
        logic           neg;
    } t_quo;

endpackage
`default_nettype wire

@@ src/mi3_if.sv @@
`default_nettype none
interface mi3_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] in_r0c0;
    logic signed [31:0] in_r0c1;
    logic signed [31:0] in_r0c2;
    logic signed [31:0] in_r1c0;
    logic signed [31:0] in_r1c1;
    logic signed [31:0] in_r1c2;
    logic signed [31:0] in_r2c0;
    logic signed [31:0] in_r2c1;
    logic signed [31:0] in_r2c2;

    modport source (
        output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
               in_r2c0, in_r2c1, in_r2c2,
        input  ready
    );
    modport sink (
        input  valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
               in_r2c0, in_r2c1, in_r2c2,
        output ready
    );
endinterface

interface mi3_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_r0c0;
    logic signed [31:0] out_r0c1;
    logic signed [31:0] out_r0c2;
    logic signed [31:0] out_r1c0;
    logic signed [31:0] out_r1c1;
    logic signed [31:0] out_r1c2;
    logic signed [31:0] out_r2c0;
    logic signed [31:0] out_r2c1;
    logic signed [31:0] out_r2c2;
    logic               singular;

    modport source (
        output valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2,
               out_r2c0, out_r2c1, out_r2c2, singular,
        input  ready
    );
    modport sink (
        input  valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2,
               out_r2c0, out_r2c1, out_r2c2, singular,
        output ready
    );
endinterface
`default_nettype wire

@@ src/matrix3x3_inverse_top.sv @@
// pipeline: 6 cofactor and determinant stages, 33 divider stages and 1 output
// register
// throughput: one matrix per cycle while the output is not held; nine divider lanes, one bit per stage
// a held output stalls the whole pipeline
// reset clears the valid bits of every stage and the output; data is not reset
`default_nettype none
module matrix3x3_inverse_top import mi3_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mi3_in_if.sink     i_in,
    mi3_out_if.source  o_out
);

    localparam int PIPE_W = FRONT_STAGES + DIV_STAGES;

    t_elem             w_m [N_ELEM];
    t_num              w_num [N_ELEM];
    t_quo              w_quo [N_ELEM];
    logic [DMAG_W-1:0] w_dmag;
    logic              w_sing;
    logic              w_en;
    logic              w_in_acc;
    logic [Q_W-1:0]    n_out [N_ELEM];

    logic [PIPE_W-1:0]     r_vld;
    logic [DIV_STAGES-1:0] r_sing;
    logic                  r_out_vld;
    logic [Q_W-1:0]        r_out [N_ELEM];
    logic                  r_out_sing;

    assign w_en       = !r_out_vld || o_out.ready;
    assign w_in_acc   = i_in.valid && w_en;
    assign i_in.ready = w_en;

    assign w_m[0] = i_in.in_r0c0;
    assign w_m[1] = i_in.in_r0c1;
    assign w_m[2] = i_in.in_r0c2;
    assign w_m[3] = i_in.in_r1c0;
    assign w_m[4] = i_in.in_r1c1;
    assign w_m[5] = i_in.in_r1c2;
    assign w_m[6] = i_in.in_r2c0;
    assign w_m[7] = i_in.in_r2c1;
    assign w_m[8] = i_in.in_r2c2;

    mi3_front u_front (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_m    (w_m),
        .o_num  (w_num),
        .o_dmag (w_dmag),
        .o_sing (w_sing)
    );

    for (genvar i = 0; i < N_ELEM; i++) begin : g_lane
        mi3_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_num  (w_num[i]),
            .i_dmag (w_dmag),
            .o_quo  (w_quo[i])
        );
    end

    // merge: sign, saturation and the singular override
    always_comb begin
        for (int i = 0; i < N_ELEM; i++) begin
            priority if (r_sing[DIV_STAGES-1]) begin
                n_out[i] = '0;
            end else if (w_quo[i].ovf) begin
                n_out[i] = w_quo[i].neg ? SAT_MIN : SAT_MAX;
            end else if (w_quo[i].neg) begin
                n_out[i] = (w_quo[i].quo > SAT_MIN) ? SAT_MIN : ~w_quo[i].quo + 1'b1;
            end else begin
                n_out[i] = (w_quo[i].quo > SAT_MAX) ? SAT_MAX : w_quo[i].quo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld     <= {r_vld[PIPE_W-2:0], w_in_acc};
            r_out_vld <= r_vld[PIPE_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sing     <= {r_sing[DIV_STAGES-2:0], w_sing};
            r_out      <= n_out;
            r_out_sing <= r_sing[DIV_STAGES-1];
        end
    end

    assign o_out.valid    = r_out_vld;
    assign o_out.out_r0c0 = r_out[0];
    assign o_out.out_r0c1 = r_out[1];
    assign o_out.out_r0c2 = r_out[2];
    assign o_out.out_r1c0 = r_out[3];
    assign o_out.out_r1c1 = r_out[4];
    assign o_out.out_r1c2 = r_out[5];
    assign o_out.out_r2c0 = r_out[6];
    assign o_out.out_r2c1 = r_out[7];
    assign o_out.out_r2c2 = r_out[8];
    assign o_out.singular = r_out_sing;

`ifndef SYNTHESIS
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.singular) |->
            (o_out.out_r0c0 == 0 && o_out.out_r0c1 == 0 && o_out.out_r0c2 == 0 &&
             o_out.out_r1c0 == 0 && o_out.out_r1c1 == 0 && o_out.out_r1c2 == 0 &&
             o_out.out_r2c0 == 0 && o_out.out_r2c1 == 0 && o_out.out_r2c2 == 0))
        else $error("singular result with nonzero entries");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved while output stalled");

    a_accept_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_vld[0])
        else $error("accepted transaction not in first stage");
`endif

endmodule
`default_nettype wire

@@ src/mi3_front.sv @@
`default_nettype none
module mi3_front import mi3_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire t_elem             i_m [N_ELEM],
    output t_num                   o_num [N_ELEM],
    output logic [DMAG_W-1:0]      o_dmag,
    output logic                   o_sing
);

    logic signed [2*MAT_W-1:0] r_pa [N_ELEM];
    logic signed [2*MAT_W-1:0] r_pb [N_ELEM];
    t_elem                     r_m1 [N_DET];
    t_elem                     r_m2 [N_DET];
    logic signed [COF_W-1:0]   r_cof2 [N_ELEM];
    logic signed [COF_W-1:0]   r_cof3 [N_ELEM];
    logic signed [COF_W-1:0]   r_cof4 [N_ELEM];
    logic signed [COF_W-1:0]   r_cof5 [N_ELEM];
    logic signed [COF_W-1:0]   r_plo [N_DET];
    logic signed [COF_W-1:0]   r_phi [N_DET];
    logic signed [DET_W-1:0]   r_part [N_DET];
    logic signed [DET_W-1:0]   r_det5;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < N_ELEM; i++) begin
                r_pa[i]   <= i_m[COF_IDX[i][0]] * i_m[COF_IDX[i][1]];
                r_pb[i]   <= i_m[COF_IDX[i][2]] * i_m[COF_IDX[i][3]];
                r_cof2[i] <= COF_W'(r_pa[i]) - COF_W'(r_pb[i]);
                r_cof3[i] <= r_cof2[i];
                r_cof4[i] <= r_cof3[i];
                r_cof5[i] <= r_cof4[i];
            end
            for (int j = 0; j < N_DET; j++) begin
                r_m1[j] <= i_m[j];
                r_m2[j] <= r_m1[j];
                // 65-bit cofactor times 32-bit entry, split at bit 32
                r_plo[j] <= $signed({1'b0, r_cof2[DET_COF[j]][MAT_W-1:0]}) * r_m2[j];
                r_phi[j] <= $signed(r_cof2[DET_COF[j]][COF_W-1:MAT_W]) * r_m2[j];
                r_part[j] <= (DET_W'(r_phi[j]) <<< MAT_W) + DET_W'(r_plo[j]);
            end
            r_det5 <= r_part[0] + r_part[1] + r_part[2];
            o_dmag <= r_det5[DET_W-1] ? DMAG_W'(-r_det5) : DMAG_W'(r_det5);
            o_sing <= (r_det5 == '0);
            for (int i = 0; i < N_ELEM; i++) begin
                o_num[i].mag <= r_cof5[i][COF_W-1] ? -r_cof5[i] : r_cof5[i];
                o_num[i].neg <= r_cof5[i][COF_W-1] ^ r_det5[DET_W-1];
            end
        end
    end

endmodule
`default_nettype wire

@@ src/mi3_lane.sv @@
`default_nettype none
module mi3_lane import mi3_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire t_num              i_num,
    input  wire logic [DMAG_W-1:0] i_dmag,
    output t_quo                   o_quo
);

    logic [REM_W-1:0]  r_rem [DIV_STAGES-1];
    logic [DMAG_W-1:0] r_den [DIV_STAGES-1];
    logic [Q_W-1:0]    r_q   [DIV_STAGES];
    logic              r_ovf [DIV_STAGES];
    logic              r_neg [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        localparam int K = Q_W - s;
        logic [REM_W-1:0]  w_rem_in;
        logic [REM_W-1:0]  w_cand;
        logic [DMAG_W-1:0] w_den_in;
        logic              w_neg_in;
        logic              w_ge;

        if (s == 0) begin : g_first
            assign w_rem_in = REM_W'(i_num.mag) << (2 * FRAC_BITS);
            assign w_den_in = i_dmag;
            assign w_neg_in = i_num.neg;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_den_in = r_den[s-1];
            assign w_neg_in = r_neg[s-1];
        end

        assign w_cand = REM_W'(w_den_in) << K;
        assign w_ge   = (w_rem_in >= w_cand);

        if (s < DIV_STAGES - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= w_ge ? w_rem_in - w_cand : w_rem_in;
                    r_den[s] <= w_den_in;
                end
            end
        end

        if (s == 0) begin : g_ovf
            // quotient at or above 2^32 saturates whatever the low bits say
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_ovf[s] <= w_ge;
                    r_q[s]   <= '0;
                    r_neg[s] <= w_neg_in;
                end
            end
        end else begin : g_bit
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_ovf[s] <= r_ovf[s-1];
                    r_q[s]   <= {r_q[s-1][Q_W-2:0], w_ge};
                    r_neg[s] <= w_neg_in;
                end
            end
        end
    end

    assign o_quo.quo = r_q[DIV_STAGES-1];
    assign o_quo.ovf = r_ovf[DIV_STAGES-1];
    assign o_quo.neg = r_neg[DIV_STAGES-1];

endmodule
`default_nettype wire

@@ test/matrix3x3_inverse_top_tb.sv @@
`default_nettype none
module matrix3x3_inverse_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mi3_pkg::*;

    localparam int FB        = 16;
    localparam int LATENCY   = 40;
    localparam int MAX_CYCLE = 2000000;

    typedef struct {
        logic signed [31:0] e [9];
        logic               singular;
    } t_inverse;

    logic i_clk;
    logic i_rst_n;

    mi3_in_if  mat_if ();
    mi3_out_if inv_if ();

    matrix3x3_inverse_top #(.FRAC_BITS(FB)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (mat_if.sink),
        .o_out   (inv_if.source)
    );

    t_inverse inverse_q [$];
    int       n_errors;
    int       cycle_cnt;
    int       send_idle_pct;
    int       recv_stall_pct;
    int       hold_cycles;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYCLE) begin
            $display("matrix3x3_inverse_top_tb: FAIL");
            $finish;
        end
    end

    // truncated, saturated cof * 2^(2*FB) / det
    function automatic logic signed [31:0] inv_entry(logic signed [127:0] cof,
                                                     logic signed [127:0] det);
        logic         neg;
        logic [191:0] num;
        logic [191:0] den;
        logic [191:0] quo;
        neg = cof[127] ^ det[127];
        num = {64'd0, (cof[127] ? -cof : cof)} << (2 * FB);
        den = {64'd0, (det[127] ? -det : det)};
        quo = num / den;
        if (neg) begin
            if (quo > 192'h80000000)
                return SAT_MIN;
            return -quo[31:0];
        end
        if (quo > 192'h7FFFFFFF)
            return SAT_MAX;
        return quo[31:0];
    endfunction

    function automatic t_inverse invert(t_elem m [9]);
        t_inverse           r;
        logic signed [127:0] cof [9];
        logic signed [127:0] det;
        for (int i = 0; i < 9; i++)
            cof[i] = 128'(m[COF_IDX[i][0]]) * 128'(m[COF_IDX[i][1]])
                   - 128'(m[COF_IDX[i][2]]) * 128'(m[COF_IDX[i][3]]);
        det = cof[0] * 128'(m[0]) + cof[3] * 128'(m[1]) + cof[6] * 128'(m[2]);
        r.singular = (det == 0);
        for (int i = 0; i < 9; i++)
            r.e[i] = r.singular ? 32'sd0 : inv_entry(cof[i], det);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
                 cycle_cnt);
        n_errors++;
    endtask

    // valid stays high between back-to-back transactions
    task automatic send_matrix(t_elem m [9]);
        while (($urandom_range(99, 0) < send_idle_pct)) begin
            mat_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        mat_if.valid   <= 1'b1;
        mat_if.in_r0c0 <= m[0];
        mat_if.in_r0c1 <= m[1];
        mat_if.in_r0c2 <= m[2];
        mat_if.in_r1c0 <= m[3];
        mat_if.in_r1c1 <= m[4];
        mat_if.in_r1c2 <= m[5];
        mat_if.in_r2c0 <= m[6];
        mat_if.in_r2c1 <= m[7];
        mat_if.in_r2c2 <= m[8];
        do
            @(posedge i_clk);
        while (!mat_if.ready);
        inverse_q.push_back(invert(m));
    endtask

    // receiver: random stall or a long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n)
            inv_if.ready <= 1'b0;
        else if (hold_cycles > 0) begin
            inv_if.ready <= 1'b0;
            hold_cycles  <= hold_cycles - 1;
        end else
            inv_if.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_inverse w;
        logic signed [31:0] got [9];
        if (i_rst_n && inv_if.valid && inv_if.ready) begin
            got = '{inv_if.out_r0c0, inv_if.out_r0c1, inv_if.out_r0c2,
                    inv_if.out_r1c0, inv_if.out_r1c1, inv_if.out_r1c2,
                    inv_if.out_r2c0, inv_if.out_r2c1, inv_if.out_r2c2};
            if (inverse_q.size() == 0)
                report_mismatch("unexpected transaction", 0, 0);
            else begin
                w = inverse_q.pop_front();
                for (int i = 0; i < 9; i++)
                    if (got[i] !== w.e[i])
                        report_mismatch($sformatf("r%0dc%0d", i / 3, i % 3),
                                        got[i], w.e[i]);
                if (inv_if.singular !== w.singular)
                    report_mismatch("singular", inv_if.singular, w.singular);
            end
        end
    end

    function automatic t_elem rand_elem(int kind);
        case (kind)
            0: return t_elem'($urandom);
            1: return t_elem'($urandom_range(32'h0003FFFF, 0) - 32'h0001FFFF);
            2: return t_elem'($urandom_range(32'h00FFFFFF, 0) - 32'h007FFFFF);
            default: return $urandom_range(1, 0) ? SAT_MAX : SAT_MIN;
        endcase
    endfunction

    task automatic wait_drained();
        mat_if.valid <= 1'b0;
        while (inverse_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_directed();
        t_elem m [9];
        int    sc [4] = '{1, 2, -1, 1000};
        m = '{default: 0};
        send_matrix(m);
        for (int k = 0; k < 4; k++) begin
            m = '{default: 0};
            m[0] = sc[k] <<< FB; m[4] = sc[k] <<< FB; m[8] = sc[k] <<< FB;
            send_matrix(m);
        end
        // tiny determinant gives saturated entries
        m = '{default: 0}; m[0] = 1; m[4] = 1; m[8] = 1;
        send_matrix(m);
        m[8] = -1;
        send_matrix(m);
        // huge determinant gives tiny entries, not singular
        m = '{default: 0}; m[0] = SAT_MIN; m[4] = SAT_MAX; m[8] = SAT_MIN;
        send_matrix(m);
        m = '{default: SAT_MIN};
        send_matrix(m);
        m = '{default: SAT_MAX};
        send_matrix(m);
        m = '{default: -1};
        send_matrix(m);
        // rank 2 and a non-exact quotient
        m = '{1 <<< FB, 2 <<< FB, 3 <<< FB, 4 <<< FB, 5 <<< FB, 6 <<< FB,
              7 <<< FB, 8 <<< FB, 9 <<< FB};
        send_matrix(m);
        m[8] = 10 <<< FB;
        send_matrix(m);
        m = '{3 <<< FB, 0, 0, 0, 3 <<< FB, 0, 0, 0, 3 <<< FB};
        send_matrix(m);
        for (int i = 0; i < 9; i++) begin
            m = '{default: 0}; m[0] = 1 <<< FB; m[4] = 1 <<< FB; m[8] = 1 <<< FB;
            m[i] = SAT_MIN;
            send_matrix(m);
        end
        wait_drained();
    endtask

    task automatic test_random(int n);
        t_elem m [9];
        int    kind;
        for (int j = 0; j < n; j++) begin
            kind = $urandom_range(3, 0);
            for (int i = 0; i < 9; i++)
                m[i] = ($urandom_range(7, 0) == 0) ? rand_elem($urandom_range(3, 0))
                                                  : rand_elem(kind);
            // make some singular by copying a row
            if ($urandom_range(9, 0) == 0) begin
                m[6] = m[0]; m[7] = m[1]; m[8] = m[2];
            end
            send_matrix(m);
        end
    endtask

    task automatic test_backpressure();
        hold_cycles <= 300;
        send_idle_pct = 0;
        test_random(120);
        wait_drained();
    endtask

    initial begin
        n_errors       = 0;
        cycle_cnt      = 0;
        hold_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        <= 1'b0;
        mat_if.valid   <= 1'b0;
        mat_if.in_r0c0 <= '0; mat_if.in_r0c1 <= '0; mat_if.in_r0c2 <= '0;
        mat_if.in_r1c0 <= '0; mat_if.in_r1c1 <= '0; mat_if.in_r1c2 <= '0;
        mat_if.in_r2c0 <= '0; mat_if.in_r2c1 <= '0; mat_if.in_r2c2 <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(500);
        send_idle_pct = 88;
        test_random(400);
        send_idle_pct = 0; recv_stall_pct = 88;
        test_random(400);
        send_idle_pct = 29; recv_stall_pct = 29;
        test_random(400);
        wait_drained();
        send_idle_pct = 0; recv_stall_pct = 0;
        test_backpressure();

        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_errors == 0)
            $display("matrix3x3_inverse_top_tb: PASS");
        else
            $display("matrix3x3_inverse_top_tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
src/mi3_pkg.sv
src/mi3_if.sv
src/mi3_front.sv
src/mi3_lane.sv
src/matrix3x3_inverse_top.sv
test/matrix3x3_inverse_top_tb.sv
